@@ hdl/assert_macros.svh @@
// Assertion helpers used by the RTL top file.
// Each macro takes a label, a condition, the expected result and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/rvd_pkg.sv @@
`timescale 1ns / 1ps
package rvd_pkg;

    // Major opcodes
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;

    // funct7 values
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MULT = 7'h01;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // Format classes
    localparam logic [2:0] FMT_R = 3'd0;
    localparam logic [2:0] FMT_I = 3'd1;
    localparam logic [2:0] FMT_L = 3'd2;
    localparam logic [2:0] FMT_S = 3'd3;
    localparam logic [2:0] FMT_B = 3'd4;
    localparam logic [2:0] FMT_U = 3'd5;
    localparam logic [2:0] FMT_J = 3'd6;

    // Mnemonic codes
    localparam logic [5:0] OP_ADD    = 6'd0;
    localparam logic [5:0] OP_SUB    = 6'd1;
    localparam logic [5:0] OP_SLL    = 6'd2;
    localparam logic [5:0] OP_SLT    = 6'd3;
    localparam logic [5:0] OP_SLTU   = 6'd4;
    localparam logic [5:0] OP_XOR    = 6'd5;
    localparam logic [5:0] OP_SRL    = 6'd6;
    localparam logic [5:0] OP_SRA    = 6'd7;
    localparam logic [5:0] OP_OR     = 6'd8;
    localparam logic [5:0] OP_AND    = 6'd9;
    localparam logic [5:0] OP_MUL    = 6'd10;
    localparam logic [5:0] OP_MULH   = 6'd11;
    localparam logic [5:0] OP_MULHSU = 6'd12;
    localparam logic [5:0] OP_MULHU  = 6'd13;
    localparam logic [5:0] OP_DIV    = 6'd14;
    localparam logic [5:0] OP_DIVU   = 6'd15;
    localparam logic [5:0] OP_REM    = 6'd16;
    localparam logic [5:0] OP_REMU   = 6'd17;
    localparam logic [5:0] OP_ADDI   = 6'd18;
    localparam logic [5:0] OP_SLTI   = 6'd19;
    localparam logic [5:0] OP_SLTIU  = 6'd20;
    localparam logic [5:0] OP_XORI   = 6'd21;
    localparam logic [5:0] OP_ORI    = 6'd22;
    localparam logic [5:0] OP_ANDI   = 6'd23;
    localparam logic [5:0] OP_SLLI   = 6'd24;
    localparam logic [5:0] OP_SRLI   = 6'd25;
    localparam logic [5:0] OP_SRAI   = 6'd26;
    localparam logic [5:0] OP_JALR   = 6'd27;
    localparam logic [5:0] OP_LB     = 6'd28;
    localparam logic [5:0] OP_LH     = 6'd29;
    localparam logic [5:0] OP_LW     = 6'd30;
    localparam logic [5:0] OP_LBU    = 6'd31;
    localparam logic [5:0] OP_LHU    = 6'd32;
    localparam logic [5:0] OP_SB     = 6'd33;
    localparam logic [5:0] OP_SH     = 6'd34;
    localparam logic [5:0] OP_SW     = 6'd35;
    localparam logic [5:0] OP_BEQ    = 6'd36;
    localparam logic [5:0] OP_BNE    = 6'd37;
    localparam logic [5:0] OP_BLT    = 6'd38;
    localparam logic [5:0] OP_BGE    = 6'd39;
    localparam logic [5:0] OP_BLTU   = 6'd40;
    localparam logic [5:0] OP_BGEU   = 6'd41;
    localparam logic [5:0] OP_LUI    = 6'd42;
    localparam logic [5:0] OP_AUIPC  = 6'd43;
    localparam logic [5:0] OP_JAL    = 6'd44;

    // Decoded instruction, passed from the decode logic to the result register
    typedef struct packed {
        logic        illegal;
        logic [2:0]  fmt;
        logic [5:0]  op;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [31:0] target;
    } dec_result_t;

endpackage

@@ hdl/rvd_decode.sv @@
`timescale 1ns / 1ps
module rvd_decode (
    input  logic [31:0]         instr_word,
    input  logic [31:0]         pc,
    output rvd_pkg::dec_result_t result
);
    import rvd_pkg::*;

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd_f;
    logic [4:0]  rs1_f;
    logic [4:0]  rs2_f;

    assign opc   = instr_word[6:0];
    assign f3    = instr_word[14:12];
    assign f7    = instr_word[31:25];
    assign rd_f  = instr_word[11:7];
    assign rs1_f = instr_word[19:15];
    assign rs2_f = instr_word[24:20];

    // Opcode classification, field selection and immediate assembly
    always_comb
    begin
        logic        bad;
        logic        tgt_en;
        logic [2:0]  fmt;
        logic [5:0]  op;
        logic [4:0]  rd_v;
        logic [4:0]  rs1_v;
        logic [4:0]  rs2_v;
        logic [31:0] imm;
        logic [31:0] i_imm;

        bad    = 1'b0;
        tgt_en = 1'b0;
        fmt    = FMT_R;
        op     = OP_ADD;
        rd_v   = rd_f;
        rs1_v  = rs1_f;
        rs2_v  = rs2_f;
        imm    = '0;
        i_imm  = {{20{instr_word[31]}}, instr_word[31:20]};

        case (opc)
            OPC_OP:
            begin
                fmt = FMT_R;
                if (f7 == F7_MULT)
                begin
                    op = OP_MUL + {3'b000, f3};
                end
                else if (f7 == F7_BASE)
                begin
                    case (f3)
                        3'd0:    op = OP_ADD;
                        3'd1:    op = OP_SLL;
                        3'd2:    op = OP_SLT;
                        3'd3:    op = OP_SLTU;
                        3'd4:    op = OP_XOR;
                        3'd5:    op = OP_SRL;
                        3'd6:    op = OP_OR;
                        default: op = OP_AND;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == 3'd0)
                begin
                    op = OP_SUB;
                end
                else if (f7 == F7_ALT && f3 == 3'd5)
                begin
                    op = OP_SRA;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            OPC_OPIMM:
            begin
                fmt   = FMT_I;
                rs2_v = '0;
                case (f3)
                    3'd0:    op = OP_ADDI;
                    3'd1:    op = OP_SLLI;
                    3'd2:    op = OP_SLTI;
                    3'd3:    op = OP_SLTIU;
                    3'd4:    op = OP_XORI;
                    3'd5:    op = OP_SRLI;
                    3'd6:    op = OP_ORI;
                    default: op = OP_ANDI;
                endcase
                // shifts carry a zero-extended shift amount
                if (f3 == 3'd1 || f3 == 3'd5)
                begin
                    imm = {27'b0, rs2_f};
                    if (f3 == 3'd5 && f7 == F7_ALT)
                        op = OP_SRAI;
                    else if (f7 != F7_BASE)
                        bad = 1'b1;
                end
                else
                begin
                    imm = i_imm;
                end
            end
            OPC_JALR:
            begin
                fmt   = FMT_I;
                op    = OP_JALR;
                imm   = i_imm;
                rs2_v = '0;
                bad   = (f3 != 3'd0);
            end
            OPC_LOAD:
            begin
                fmt   = FMT_L;
                imm   = i_imm;
                rs2_v = '0;
                case (f3)
                    3'd0:    op = OP_LB;
                    3'd1:    op = OP_LH;
                    3'd2:    op = OP_LW;
                    3'd4:    op = OP_LBU;
                    3'd5:    op = OP_LHU;
                    default: bad = 1'b1;
                endcase
            end
            OPC_STORE:
            begin
                fmt  = FMT_S;
                rd_v = '0;
                imm  = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
                if (f3 > 3'd2)
                    bad = 1'b1;
                else
                    op = OP_SB + {3'b000, f3};
            end
            OPC_BRANCH:
            begin
                fmt    = FMT_B;
                rd_v   = '0;
                tgt_en = 1'b1;
                imm    = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                          instr_word[30:25], instr_word[11:8], 1'b0};
                case (f3)
                    3'd0:    op = OP_BEQ;
                    3'd1:    op = OP_BNE;
                    3'd4:    op = OP_BLT;
                    3'd5:    op = OP_BGE;
                    3'd6:    op = OP_BLTU;
                    3'd7:    op = OP_BGEU;
                    default: bad = 1'b1;
                endcase
            end
            OPC_LUI, OPC_AUIPC:
            begin
                fmt   = FMT_U;
                op    = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
                imm   = {instr_word[31:12], 12'b0};
                rs1_v = '0;
                rs2_v = '0;
            end
            OPC_JAL:
            begin
                fmt    = FMT_J;
                op     = OP_JAL;
                tgt_en = 1'b1;
                imm    = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                          instr_word[20], instr_word[30:21], 1'b0};
                rs1_v  = '0;
                rs2_v  = '0;
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase

        // An illegal word clears every field but the flag
        if (bad)
        begin
            result         = '0;
            result.illegal = 1'b1;
        end
        else
        begin
            result.illegal = 1'b0;
            result.fmt     = fmt;
            result.op      = op;
            result.rd      = rd_v;
            result.rs1     = rs1_v;
            result.rs2     = rs2_v;
            result.imm     = imm;
            result.target  = tgt_en ? (pc + imm) : '0;
        end
    end

endmodule

@@ hdl/rv32im_instruction_decoder_top.sv @@
`timescale 1ns / 1ps
// RV32IM instruction decoder: input register, decode logic, result register.
// An accepted word is held in the input register and moves, decoded, into the result
// register once that register is empty or being read.
// Throughput: one instruction per cycle; the input side stalls only while both
// registers are full and out_ready is low.
// Reset (rst_n, async, active low) empties both pipeline stages; no other state.
`include "assert_macros.svh"
module rv32im_instruction_decoder_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        instr_word,
    input  logic [31:0]        pc,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               illegal,
    output logic [2:0]         format,
    output logic [5:0]         op_code,
    output logic [4:0]         rd,
    output logic [4:0]         rs1,
    output logic [4:0]         rs2,
    output logic signed [31:0] immediate,
    output logic [31:0]        target
);
    import rvd_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [31:0] instr_reg;
    logic [31:0] pc_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    dec_result_t result_reg;
    dec_result_t dec_result;
    logic        out_take;
    logic        s1_move;
    logic        in_take;

    // Pipeline flow control
    assign out_take       = out_valid_reg & out_ready;
    assign s1_move        = s1_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready       = ~s1_valid_reg | s1_move;
    assign in_take        = in_valid & in_ready;
    assign s1_valid_next  = in_take | (s1_valid_reg & ~s1_move);
    assign out_valid_next = s1_move | (out_valid_reg & ~out_take);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            instr_reg <= instr_word;
            pc_reg    <= pc;
        end
    end

    rvd_decode u_decode (
        .instr_word (instr_reg),
        .pc         (pc_reg),
        .result     (dec_result)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            result_reg <= dec_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign illegal   = result_reg.illegal;
    assign format    = result_reg.fmt;
    assign op_code   = result_reg.op;
    assign rd        = result_reg.rd;
    assign rs1       = result_reg.rs1;
    assign rs2       = result_reg.rs2;
    assign immediate = signed'(result_reg.imm);
    assign target    = result_reg.target;

    // Checks
    `ASSERT_IMPL(a_illegal_clear, out_valid_reg && result_reg.illegal,
        result_reg.fmt == FMT_R && result_reg.op == OP_ADD && result_reg.imm == '0
        && result_reg.target == '0, "illegal result carries nonzero fields")
    `ASSERT_IMPL(a_target_only_bj,
        out_valid_reg && result_reg.fmt != FMT_B && result_reg.fmt != FMT_J,
        result_reg.target == '0, "target set outside branch or jal")
    `ASSERT_IMPL(a_op_range, out_valid_reg, result_reg.op <= OP_JAL,
        "mnemonic code out of range")
    `ASSERT_NEXT(a_stage_advance, s1_valid_reg && !out_valid_reg, out_valid_reg,
        "decoded word did not reach result register")

endmodule

@@ sim/rv32im_instruction_decoder_top_test.sv @@
`timescale 1ns / 1ps
module rv32im_instruction_decoder_top_test;
    import rvd_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 800;
    localparam int MAX_REPORTS  = 10;

    // Marks an unused funct3 slot in the decode tables
    localparam logic [5:0] OP_NONE = 6'h3F;

    // funct3 values that select sub/sra/shift variants
    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_SR  = 3'd5;

    // Mnemonic per funct3, element 0 on the right
    localparam logic [7:0][5:0] BASE_R_OPS = {OP_AND, OP_OR, OP_SRL, OP_XOR,
                                              OP_SLTU, OP_SLT, OP_SLL, OP_ADD};
    localparam logic [7:0][5:0] MUL_OPS    = {OP_REMU, OP_REM, OP_DIVU, OP_DIV,
                                              OP_MULHU, OP_MULHSU, OP_MULH, OP_MUL};
    localparam logic [7:0][5:0] OPIMM_OPS  = {OP_ANDI, OP_ORI, OP_SRLI, OP_XORI,
                                              OP_SLTIU, OP_SLTI, OP_SLLI, OP_ADDI};
    localparam logic [7:0][5:0] LOAD_OPS   = {OP_NONE, OP_NONE, OP_LHU, OP_LBU,
                                              OP_NONE, OP_LW, OP_LH, OP_LB};
    localparam logic [7:0][5:0] STORE_OPS  = {OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                                              OP_NONE, OP_SW, OP_SH, OP_SB};
    localparam logic [7:0][5:0] BRANCH_OPS = {OP_BGEU, OP_BLTU, OP_BGE, OP_BLT,
                                              OP_NONE, OP_NONE, OP_BNE, OP_BEQ};
    localparam logic [7:0][5:0] JALR_OPS   = {OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                                              OP_NONE, OP_NONE, OP_NONE, OP_JALR};

    // R and op-imm sit at the low end so they can be weighted up
    localparam logic [8:0][6:0] MAJOR_OPCODES = {OPC_JAL, OPC_AUIPC, OPC_LUI,
                                                 OPC_BRANCH, OPC_STORE, OPC_LOAD,
                                                 OPC_JALR, OPC_OPIMM, OPC_OP};

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [31:0]        instr_word;
    logic [31:0]        pc;
    logic               out_valid;
    logic               out_ready;
    logic               illegal;
    logic [2:0]         format;
    logic [5:0]         op_code;
    logic [4:0]         rd;
    logic [4:0]         rs1;
    logic [4:0]         rs2;
    logic signed [31:0] immediate;
    logic [31:0]        target;

    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles = 0;

    // Decoded-instruction predictor plus queue of expected decodes
    class decode_scoreboard;
        dec_result_t expected_decodes[$];
        int unsigned error_count;

        function dec_result_t decode(logic [31:0] w, logic [31:0] addr);
            dec_result_t r;
            logic [2:0] f3;
            logic [6:0] f7;
            logic bad;
            r = '0;
            bad = 1'b0;
            f3 = w[14:12];
            f7 = w[31:25];
            r.rd = w[11:7];
            r.rs1 = w[19:15];
            r.rs2 = w[24:20];
            case (w[6:0])
                OPC_OP:
                begin
                    r.fmt = FMT_R;
                    if (f7 == F7_MULT) r.op = MUL_OPS[f3];
                    else if (f7 == F7_BASE) r.op = BASE_R_OPS[f3];
                    else if (f7 == F7_ALT && f3 == F3_ADD) r.op = OP_SUB;
                    else if (f7 == F7_ALT && f3 == F3_SR) r.op = OP_SRA;
                    else bad = 1'b1;
                end
                OPC_OPIMM:
                begin
                    r.fmt = FMT_I;
                    r.op = OPIMM_OPS[f3];
                    if (f3 == F3_SLL || f3 == F3_SR)
                    begin
                        // shift amount, zero-extended
                        r.imm = {27'd0, w[24:20]};
                        if (f3 == F3_SR && f7 == F7_ALT) r.op = OP_SRAI;
                        else if (f7 != F7_BASE) bad = 1'b1;
                    end
                    else
                    begin
                        r.imm = {{20{w[31]}}, w[31:20]};
                    end
                    r.rs2 = '0;
                end
                OPC_JALR:
                begin
                    r.fmt = FMT_I;
                    r.op = OP_JALR;
                    bad = (JALR_OPS[f3] == OP_NONE);
                    r.imm = {{20{w[31]}}, w[31:20]};
                    r.rs2 = '0;
                end
                OPC_LOAD:
                begin
                    r.fmt = FMT_L;
                    r.op = LOAD_OPS[f3];
                    bad = (LOAD_OPS[f3] == OP_NONE);
                    r.imm = {{20{w[31]}}, w[31:20]};
                    r.rs2 = '0;
                end
                OPC_STORE:
                begin
                    r.fmt = FMT_S;
                    r.op = STORE_OPS[f3];
                    bad = (STORE_OPS[f3] == OP_NONE);
                    r.imm = {{20{w[31]}}, w[31:25], w[11:7]};
                    r.rd = '0;
                end
                OPC_BRANCH:
                begin
                    r.fmt = FMT_B;
                    r.op = BRANCH_OPS[f3];
                    bad = (BRANCH_OPS[f3] == OP_NONE);
                    r.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                    r.target = addr + r.imm;
                    r.rd = '0;
                end
                OPC_LUI, OPC_AUIPC:
                begin
                    r.fmt = FMT_U;
                    r.op = (w[6:0] == OPC_LUI) ? OP_LUI : OP_AUIPC;
                    r.imm = {w[31:12], 12'd0};
                    r.rs1 = '0;
                    r.rs2 = '0;
                end
                OPC_JAL:
                begin
                    r.fmt = FMT_J;
                    r.op = OP_JAL;
                    r.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                    r.target = addr + r.imm;
                    r.rs1 = '0;
                    r.rs2 = '0;
                end
                default: bad = 1'b1;
            endcase
            // illegal words clear every other field
            if (bad)
            begin
                r = '0;
                r.illegal = 1'b1;
            end
            return r;
        endfunction

        function void note_instr(logic [31:0] w, logic [31:0] addr);
            expected_decodes.push_back(decode(w, addr));
        endfunction

        function int pending();
            return expected_decodes.size();
        endfunction

        // One-line dump of a decoded transaction
        function string show(dec_result_t r);
            return $sformatf("ill=%0b fmt=%0d op=%0d rd=%0d rs1=%0d rs2=%0d imm=%h tgt=%h",
                             r.illegal, r.fmt, r.op, r.rd, r.rs1, r.rs2, r.imm, r.target);
        endfunction

        function void check_result(dec_result_t got);
            dec_result_t exp;
            logic diff;
            if (expected_decodes.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result: op=%0d ill=%0b", $realtime,
                             got.op, got.illegal);
                return;
            end
            exp = expected_decodes.pop_front();
            diff = (got.illegal !== exp.illegal) || (got.fmt !== exp.fmt)
                || (got.op !== exp.op) || (got.rd !== exp.rd)
                || (got.rs1 !== exp.rs1) || (got.rs2 !== exp.rs2)
                || (got.imm !== exp.imm) || (got.target !== exp.target);
            if (diff)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("[%0t] mismatch exp: %s", $realtime, show(exp));
                    $display("[%0t] mismatch act: %s", $realtime, show(got));
                end
            end
        endfunction
    endclass

    decode_scoreboard sb = new();

    rv32im_instruction_decoder_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .instr_word (instr_word),
        .pc         (pc),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .illegal    (illegal),
        .format     (format),
        .op_code    (op_code),
        .rd         (rd),
        .rs1        (rs1),
        .rs2        (rs2),
        .immediate  (immediate),
        .target     (target)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Build a word from its fields
    function automatic logic [31:0] enc(logic [6:0] opc, logic [2:0] f3, logic [6:0] f7,
                                        logic [4:0] d, logic [4:0] s1, logic [4:0] s2);
        return {f7, s2, s1, f3, d, opc};
    endfunction

    // Random funct3 whose table slot is used (unused = 0) or unused (unused = 1)
    function automatic logic [2:0] pick_f3(logic [7:0][5:0] ops, bit unused);
        logic [2:0] f3;
        f3 = 3'($urandom_range(7));
        while ((ops[f3] == OP_NONE) != unused)
            f3 = 3'($urandom_range(7));
        return f3;
    endfunction

    // Mostly well-formed words with random fields, some broken and some noise
    function automatic logic [31:0] random_instr();
        logic [31:0] w;
        int unsigned pick;
        logic [3:0] idx;
        w = $urandom();
        pick = $urandom_range(99);
        if (pick < 8)
            return w;
        idx = 4'($urandom_range(10));
        if (idx > 4'd8)
            idx = idx - 4'd9;
        w[6:0] = MAJOR_OPCODES[idx];
        // broken: known opcode, random funct3/funct7
        if (pick < 20)
            return w;
        case (w[6:0])
            OPC_OP:
            begin
                case ($urandom_range(2))
                    0:
                    begin
                        w[31:25] = F7_BASE;
                        w[14:12] = pick_f3(BASE_R_OPS, 1'b0);
                    end
                    1:
                    begin
                        w[31:25] = F7_MULT;
                        w[14:12] = 3'($urandom_range(7));
                    end
                    default:
                    begin
                        w[31:25] = F7_ALT;
                        w[14:12] = $urandom_range(1) ? F3_ADD : F3_SR;
                    end
                endcase
            end
            OPC_OPIMM:
            begin
                w[14:12] = pick_f3(OPIMM_OPS, 1'b0);
                if (w[14:12] == F3_SLL)
                    w[31:25] = F7_BASE;
                else if (w[14:12] == F3_SR)
                    w[31:25] = $urandom_range(1) ? F7_ALT : F7_BASE;
            end
            OPC_JALR:   w[14:12] = pick_f3(JALR_OPS, 1'b0);
            OPC_LOAD:   w[14:12] = pick_f3(LOAD_OPS, 1'b0);
            OPC_STORE:  w[14:12] = pick_f3(STORE_OPS, 1'b0);
            OPC_BRANCH: w[14:12] = pick_f3(BRANCH_OPS, 1'b0);
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] random_pc();
        case ($urandom_range(19))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'hFFFF_F000 | $urandom_range(4095);
            default: return $urandom();
        endcase
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_instr(input logic [31:0] w, input logic [31:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        instr_word <= w;
        pc <= addr;
        do @(posedge clk); while (!in_ready);
        sb.note_instr(w, addr);
    endtask

    // Hold off the sender until every outstanding decode has come back
    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        // whole-word extremes: opcode 0 and opcode 7F are both illegal
        send_instr(32'h0000_0000, 32'h0000_0000);
        send_instr(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // R format: base, alternate, M extension, bad funct7
        send_instr(enc(OPC_OP, F3_ADD, F7_BASE, 5'd31, 5'd31, 5'd31), random_pc());
        send_instr(enc(OPC_OP, F3_ADD, F7_ALT, 5'd0, 5'd0, 5'd0), random_pc());
        send_instr(enc(OPC_OP, F3_SR, F7_ALT, 5'd5, 5'd6, 5'd7), random_pc());
        send_instr(enc(OPC_OP, pick_f3(MUL_OPS, 1'b0), F7_MULT, 5'd1, 5'd2, 5'd3),
                   random_pc());
        send_instr(enc(OPC_OP, F3_SLL, F7_ALT, 5'd1, 5'd2, 5'd3), random_pc());
        send_instr(enc(OPC_OP, pick_f3(BASE_R_OPS, 1'b0), 7'h7F, 5'd9, 5'd9, 5'd9),
                   random_pc());
        // op-imm immediate extremes and shifts
        send_instr(enc(OPC_OPIMM, F3_ADD, 7'h40, 5'd1, 5'd2, 5'd0), random_pc());
        send_instr(enc(OPC_OPIMM, pick_f3(OPIMM_OPS, 1'b0), 7'h3F, 5'd31, 5'd0, 5'd31),
                   random_pc());
        send_instr(enc(OPC_OPIMM, F3_SLL, F7_BASE, 5'd4, 5'd8, 5'd31), random_pc());
        send_instr(enc(OPC_OPIMM, F3_SR, F7_ALT, 5'd4, 5'd8, 5'd31), random_pc());
        send_instr(enc(OPC_OPIMM, F3_SLL, F7_ALT, 5'd4, 5'd8, 5'd3), random_pc());
        send_instr(enc(OPC_OPIMM, F3_SR, F7_MULT, 5'd4, 5'd8, 5'd3), random_pc());
        // jalr, loads, stores: legal and unused funct3
        send_instr(enc(OPC_JALR, pick_f3(JALR_OPS, 1'b0), 7'h7F, 5'd1, 5'd2, 5'd31),
                   random_pc());
        send_instr(enc(OPC_JALR, pick_f3(JALR_OPS, 1'b1), 7'h00, 5'd1, 5'd2, 5'd0),
                   random_pc());
        send_instr(enc(OPC_LOAD, pick_f3(LOAD_OPS, 1'b0), 7'h40, 5'd3, 5'd4, 5'd0),
                   random_pc());
        send_instr(enc(OPC_LOAD, pick_f3(LOAD_OPS, 1'b1), 7'h01, 5'd3, 5'd4, 5'd0),
                   random_pc());
        send_instr(enc(OPC_STORE, pick_f3(STORE_OPS, 1'b0), 7'h7F, 5'd31, 5'd4, 5'd5),
                   random_pc());
        send_instr(enc(OPC_STORE, pick_f3(STORE_OPS, 1'b1), 7'h00, 5'd0, 5'd4, 5'd5),
                   random_pc());
        // branches: most negative offset wrapping below zero, most positive above
        send_instr(enc(OPC_BRANCH, pick_f3(BRANCH_OPS, 1'b0), 7'h40, 5'd0, 5'd1, 5'd2),
                   32'h0000_0000);
        send_instr(enc(OPC_BRANCH, pick_f3(BRANCH_OPS, 1'b0), 7'h3F, 5'd31, 5'd1, 5'd2),
                   32'hFFFF_FFF0);
        send_instr(enc(OPC_BRANCH, pick_f3(BRANCH_OPS, 1'b1), 7'h3F, 5'd31, 5'd1, 5'd2),
                   random_pc());
        // upper immediates and jal extremes
        send_instr({20'hFFFFF, 5'd31, OPC_LUI}, random_pc());
        send_instr({20'h80000, 5'd0, OPC_AUIPC}, random_pc());
        send_instr({1'b1, 10'd0, 1'b0, 8'd0, 5'd0, OPC_JAL}, 32'h0000_0000);
        send_instr({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd31, OPC_JAL}, 32'hFFFF_FFFF);
    endtask

    task automatic run_phase(input int n, input int s_idle, input int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                drain_pipe();
            send_instr(random_instr(), random_pc());
        end
        drain_pipe();
    endtask

    // Receiver: check each accepted transaction, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({illegal, format, op_code, rd, rs1, rs2, immediate, target});
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: too long with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        instr_word <= '0;
        pc <= '0;
        out_ready <= 1'b0;
        send_idle_pct = 31;
        recv_idle_pct = 77;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain_pipe();
        run_phase(RANDOM_ITEMS / 3, 31, 77);
        run_phase(RANDOM_ITEMS / 3, 77, 31);
        run_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0, 0);

        // catch any stray result after the last one
        in_valid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
